// File: hdl/u8v_pkg.sv
// Shared types, byte constants and range checks for the UTF-8 string checker.
`default_nettype none

package u8v_pkg;

    localparam int unsigned BYTE_W = 8;

    // Range allowed for the next continuation byte
    typedef enum logic [2:0] {
        RULE_ANY = 3'd0,  // 80-BF
        RULE_E0  = 3'd1,  // A0-BF
        RULE_ED  = 3'd2,  // 80-9F
        RULE_F0  = 3'd3,  // 90-BF
        RULE_F4  = 3'd4   // 80-8F
    } t_rule;

    typedef struct packed {
        logic [1:0] cont_left;
        t_rule      rule;
        logic       err;
    } t_dec_state;

    localparam t_dec_state DEC_IDLE = '{cont_left: 2'd0, rule: RULE_ANY, err: 1'b0};

    localparam logic [BYTE_W-1:0] B_NUL    = 8'h00;
    localparam logic [BYTE_W-1:0] B_ASCII  = 8'h7f;
    localparam logic [BYTE_W-1:0] B_CONT   = 8'h80;
    localparam logic [BYTE_W-1:0] B_C8F    = 8'h8f;
    localparam logic [BYTE_W-1:0] B_C90    = 8'h90;
    localparam logic [BYTE_W-1:0] B_C9F    = 8'h9f;
    localparam logic [BYTE_W-1:0] B_CA0    = 8'ha0;
    localparam logic [BYTE_W-1:0] B_CONT_H = 8'hbf;
    localparam logic [BYTE_W-1:0] B_L2_LO  = 8'hc2;
    localparam logic [BYTE_W-1:0] B_L2_HI  = 8'hdf;
    localparam logic [BYTE_W-1:0] B_L3_LO  = 8'he0;
    localparam logic [BYTE_W-1:0] B_L3_ED  = 8'hed;
    localparam logic [BYTE_W-1:0] B_L3_HI  = 8'hef;
    localparam logic [BYTE_W-1:0] B_L4_LO  = 8'hf0;
    localparam logic [BYTE_W-1:0] B_L4_HI  = 8'hf4;

    function automatic logic cont_ok(input logic [BYTE_W-1:0] b, input t_rule rule);
        logic ok;
        case (rule)
            RULE_E0: ok = (b >= B_CA0)  && (b <= B_CONT_H);
            RULE_ED: ok = (b >= B_CONT) && (b <= B_C9F);
            RULE_F0: ok = (b >= B_C90)  && (b <= B_CONT_H);
            RULE_F4: ok = (b >= B_CONT) && (b <= B_C8F);
            default: ok = (b >= B_CONT) && (b <= B_CONT_H);
        endcase
        return ok;
    endfunction

endpackage

`default_nettype wire

// File: hdl/u8v_dec.sv
// Next-state decode for one byte: continuation check or lead byte classification.
`default_nettype none

module u8v_dec (
    input  wire logic [u8v_pkg::BYTE_W-1:0] i_byte,
    input  wire u8v_pkg::t_dec_state        i_state,
    output u8v_pkg::t_dec_state             o_state,
    output logic                            o_valid
);

    always_comb begin
        o_state      = i_state;
        o_state.rule = u8v_pkg::RULE_ANY;
        if (i_state.cont_left != 2'd0) begin
            if (u8v_pkg::cont_ok(i_byte, i_state.rule)) begin
                o_state.cont_left = i_state.cont_left - 2'd1;
            end else begin
                // bad continuation: drop the sequence, byte is consumed
                o_state.err       = 1'b1;
                o_state.cont_left = 2'd0;
            end
        end else begin
            if (i_byte == u8v_pkg::B_NUL) begin
                o_state.err = 1'b1;
            end else if (i_byte <= u8v_pkg::B_ASCII) begin
                o_state.cont_left = 2'd0;
            end else if (i_byte inside {[u8v_pkg::B_L2_LO:u8v_pkg::B_L2_HI]}) begin
                o_state.cont_left = 2'd1;
            end else if (i_byte inside {[u8v_pkg::B_L3_LO:u8v_pkg::B_L3_HI]}) begin
                o_state.cont_left = 2'd2;
                if (i_byte == u8v_pkg::B_L3_LO) begin
                    o_state.rule = u8v_pkg::RULE_E0;
                end else if (i_byte == u8v_pkg::B_L3_ED) begin
                    o_state.rule = u8v_pkg::RULE_ED;
                end
            end else if (i_byte inside {[u8v_pkg::B_L4_LO:u8v_pkg::B_L4_HI]}) begin
                o_state.cont_left = 2'd3;
                if (i_byte == u8v_pkg::B_L4_LO) begin
                    o_state.rule = u8v_pkg::RULE_F0;
                end else if (i_byte == u8v_pkg::B_L4_HI) begin
                    o_state.rule = u8v_pkg::RULE_F4;
                end
            end else begin
                // C0, C1, F5-FF, stray continuation
                o_state.err = 1'b1;
            end
        end
    end

    assign o_valid = !o_state.err && (o_state.cont_left == 2'd0);

endmodule

`default_nettype wire

// File: hdl/utf8_validator_no_nul_unit.sv
// Top level of the strict UTF-8 string checker with NUL rejection.
//
//  channel  | dir | tdata bits (low up)   | tlast      | transfers
//  s_axis   | in  | [7:0] byte_value      | last_byte  | one per byte
//  m_axis   | out | [0] string_valid,pad0 | -          | one per string
//
// One byte per clock while s_axis_tready is high; the decode state updates in the cycle a byte transfers.
// The verdict is registered and appears in the cycle after the last byte transfers.
// Synchronous active-low reset clears decode state and the output valid flag; the verdict bit is not reset.
// While a verdict waits on m_axis_tready, s_axis_tready is low; a taken
// verdict frees the register in the same cycle, so no bubble at full rate.
`default_nettype none

module utf8_validator_no_nul_unit (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       s_axis_tvalid,
    output logic            s_axis_tready,
    input  wire logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  wire logic       s_axis_tlast,   // last_byte
    output logic            m_axis_tvalid,
    input  wire logic       m_axis_tready,
    output logic [7:0]      m_axis_tdata    // [0] string_valid, [7:1] zero
);

    u8v_pkg::t_dec_state r_state;
    u8v_pkg::t_dec_state n_state;
    logic                n_valid;
    logic                r_out_vld;
    logic                r_out_bit;
    logic                in_xfer;

    assign s_axis_tready = !r_out_vld || m_axis_tready;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;

    u8v_dec u_dec (
        .i_byte  (s_axis_tdata),
        .i_state (r_state),
        .o_state (n_state),
        .o_valid (n_valid)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= u8v_pkg::DEC_IDLE;
            r_out_vld <= 1'b0;
        end else begin
            if (in_xfer) begin
                r_state <= s_axis_tlast ? u8v_pkg::DEC_IDLE : n_state;
            end
            if (in_xfer && s_axis_tlast) begin
                r_out_vld <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer && s_axis_tlast) begin
            r_out_bit <= n_valid;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata  = {7'd0, r_out_bit};

endmodule

`default_nettype wire

// File: hdl/u8v_chk.sv
// Port-level checker for the UTF-8 string checker, bound to the top level.
`default_nettype none

module u8v_chk (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       s_axis_tvalid,
    input wire logic       s_axis_tready,
    input wire logic [7:0] s_axis_tdata,
    input wire logic       s_axis_tlast,
    input wire logic       m_axis_tvalid,
    input wire logic       m_axis_tready,
    input wire logic [7:0] m_axis_tdata
);

    // stalled verdict holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("verdict changed while stalled");

    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("verdict valid after reset");

    // a NUL as final byte always fails the string
    a_nul_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast && s_axis_tdata == 8'h00
        |=> m_axis_tvalid && !m_axis_tdata[0])
        else $error("NUL final byte passed");

    // a multibyte lead as final byte is either cut short or a bad continuation
    a_lead_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready && s_axis_tlast
            && s_axis_tdata >= 8'hc2 && s_axis_tdata <= 8'hf4
        |=> m_axis_tvalid && !m_axis_tdata[0])
        else $error("string ending in a lead byte passed");

    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tdata[7:1] == 7'd0)
        else $error("verdict padding not zero");

endmodule

bind utf8_validator_no_nul_unit u8v_chk u_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
